### hdl/pfnm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfnm_pkg
// Shared types, constants and the fade arithmetic for the palette fade
// nearest-match block.
// ----------------------------------------------------------------------------
package pfnm_pkg;

   // default palette depth
   localparam int PALETTE_ENTRIES = 256;

   // field widths
   localparam int GUN_W   = 8;
   localparam int INDEX_W = 8;
   localparam int FRAC_W  = 8;
   localparam int CSR_W   = 8;
   localparam int CSR_IDX_W = 1;

   // sum of three squared 8-bit gun differences fits in 18 bits
   localparam int DIST_W = 18;

   // item mode codes
   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_COLOR = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_FADE_FRAC    = 1'b1;

   typedef struct packed {
      logic [GUN_W-1:0] red;
      logic [GUN_W-1:0] green;
      logic [GUN_W-1:0] blue;
   } rgb_type;

   typedef struct packed {
      logic               mode;
      logic [INDEX_W-1:0] entry_index;
      logic [GUN_W-1:0]   red_gun;
      logic [GUN_W-1:0]   green_gun;
      logic [GUN_W-1:0]   blue_gun;
   } req_type;

   typedef struct packed {
      logic [INDEX_W-1:0] queried_index;
      logic [INDEX_W-1:0] match_color;
   } rsp_type;

   // fade one gun toward the target: orig - floor((orig - targ) * half / 128)
   function automatic logic [GUN_W-1:0] fade_gun(
      input logic [GUN_W-1:0] orig,
      input logic [GUN_W-1:0] targ,
      input logic [6:0]       half
   );
      logic signed [GUN_W:0]  diff;
      logic signed [GUN_W+8:0] prod;
      logic signed [GUN_W+8:0] quot;
      diff = $signed({1'b0, orig}) - $signed({1'b0, targ});
      prod = diff * $signed({1'b0, half});
      quot = prod >>> 7;
      return orig - quot[GUN_W-1:0];
   endfunction

endpackage

### hdl/pfnm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfnm_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module pfnm_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/pfnm_dist.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfnm_dist
// Shared distance unit: squares of the three gun differences are registered,
// and their sum is formed combinationally from the square registers.
// ----------------------------------------------------------------------------
module pfnm_dist (
   input  logic                          clock,
   input  logic                          enable,
   input  pfnm_pkg::rgb_type             entry,
   input  pfnm_pkg::rgb_type             ideal,
   output logic [pfnm_pkg::DIST_W-1:0]   sum_sq
);

   logic [pfnm_pkg::GUN_W-1:0]   ent_gun [3];
   logic [pfnm_pkg::GUN_W-1:0]   idl_gun [3];
   logic [pfnm_pkg::GUN_W-1:0]   abs_diff [3];
   logic [2*pfnm_pkg::GUN_W-1:0] sq_in [3];
   logic [2*pfnm_pkg::GUN_W-1:0] sq_ff [3];

   assign ent_gun[0] = entry.red;
   assign ent_gun[1] = entry.green;
   assign ent_gun[2] = entry.blue;
   assign idl_gun[0] = ideal.red;
   assign idl_gun[1] = ideal.green;
   assign idl_gun[2] = ideal.blue;

   // absolute difference and square per gun
   always_comb begin
      for (int g = 0; g < 3; g++) begin
         if (ent_gun[g] >= idl_gun[g]) begin
            abs_diff[g] = ent_gun[g] - idl_gun[g];
         end else begin
            abs_diff[g] = idl_gun[g] - ent_gun[g];
         end
         sq_in[g] = abs_diff[g] * abs_diff[g];
      end
   end

   // square registers
   always_ff @(posedge clock) begin
      if (enable) begin
         for (int g = 0; g < 3; g++) begin
            sq_ff[g] <= sq_in[g];
         end
      end
   end

   // sum of squares
   assign sum_sq = pfnm_pkg::DIST_W'(sq_ff[0]) + pfnm_pkg::DIST_W'(sq_ff[1])
                 + pfnm_pkg::DIST_W'(sq_ff[2]);

endmodule

### hdl/palette_fade_nearest_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palette_fade_nearest_match
// Palette store with a fade-and-search nearest color match.
// ----------------------------------------------------------------------------
// Load item: written into the palette RAM at acceptance if its index is in
// range; no result. Query item: the remap color is faded toward the target,
// the single distance unit reads one palette word per cycle, and the next
// item is taken in the cycle after the result is loaded; index 0 matches 0.
// Reset clears the sequencer, the result valid flag and both config registers;
// the palette RAM is not cleared and must be loaded before queries.
// ----------------------------------------------------------------------------
module palette_fade_nearest_match #(
   parameter int PALETTE_ENTRIES = pfnm_pkg::PALETTE_ENTRIES
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  pfnm_pkg::req_type                  req_data,
   // response channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output pfnm_pkg::rsp_type                  rsp_data,
   // configuration port
   input  logic                               csr_wr_en,
   input  logic [pfnm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pfnm_pkg::CSR_W-1:0]         csr_wdata
);

   localparam int AW = $clog2(PALETTE_ENTRIES);
   localparam int IW = pfnm_pkg::INDEX_W;

   typedef enum logic [6:0] {
      S_IDLE    = 7'b0000001,
      S_RD_ORIG = 7'b0000010,
      S_RD_TARG = 7'b0000100,
      S_FADE    = 7'b0001000,
      S_SCAN    = 7'b0010000,
      S_DRAIN   = 7'b0100000,
      S_DONE    = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   logic [IW-1:0]                 target_ff;
   logic [pfnm_pkg::FRAC_W-1:0]   frac_ff;
   logic [IW-1:0]                 idx_ff;
   logic                          idx_ok_ff;
   logic                          tgt_ok_ff;
   pfnm_pkg::rgb_type             orig_ff;
   pfnm_pkg::rgb_type             ideal_ff;
   pfnm_pkg::rgb_type             targ;
   pfnm_pkg::rgb_type             rd_rgb;
   logic [AW-1:0]                 cnt_ff;
   logic                          p1_valid_ff;
   logic                          p2_valid_ff;
   logic [AW-1:0]                 cand1_ff;
   logic [AW-1:0]                 cand2_ff;
   logic [IW-1:0]                 best_ff;
   logic [pfnm_pkg::DIST_W-1:0]   bestd_ff;
   logic [pfnm_pkg::DIST_W-1:0]   cand_dist;
   logic                          rsp_valid_ff;
   pfnm_pkg::rsp_type             rsp_ff;

   logic                          req_accept;
   logic                          load_wr;
   logic                          req_idx_ok;
   logic                          s0_valid;
   logic                          scan_last;
   logic                          rsp_free;
   logic [AW-1:0]                 rd_addr;
   logic [23:0]                   rd_data;

   // handshake
   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   // palette load decode
   assign req_idx_ok = {1'b0, req_data.entry_index} < (IW + 1)'(PALETTE_ENTRIES);
   assign load_wr    = req_accept && (req_data.mode == pfnm_pkg::MODE_LOAD) && req_idx_ok;

   // scan issue and skip of the remap index itself
   assign s0_valid  = (state_ff == S_SCAN) && (IW'(cnt_ff) != idx_ff);
   assign scan_last = (cnt_ff == AW'(PALETTE_ENTRIES - 1));

   // read address select
   always_comb begin
      unique case (state_ff)
         S_RD_ORIG: rd_addr = idx_ff[AW-1:0];
         S_RD_TARG: rd_addr = target_ff[AW-1:0];
         default:   rd_addr = cnt_ff;
      endcase
   end

   pfnm_ram #(
      .WIDTH (24),
      .DEPTH (PALETTE_ENTRIES)
   ) u_palette (
      .clock   (clock),
      .wr_en   (load_wr),
      .wr_addr (req_data.entry_index[AW-1:0]),
      .wr_data ({req_data.red_gun, req_data.green_gun, req_data.blue_gun}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_rgb = rd_data;
   assign targ   = tgt_ok_ff ? rd_rgb : '0;

   pfnm_dist u_dist (
      .clock  (clock),
      .enable (p1_valid_ff),
      .entry  (rd_rgb),
      .ideal  (ideal_ff),
      .sum_sq (cand_dist)
   );

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept && (req_data.mode == pfnm_pkg::MODE_QUERY)) begin
               if (req_data.entry_index == '0) begin
                  state_in = S_DONE;
               end else begin
                  state_in = S_RD_ORIG;
               end
            end
         end
         S_RD_ORIG: state_in = S_RD_TARG;
         S_RD_TARG: state_in = S_FADE;
         S_FADE:    state_in = S_SCAN;
         S_SCAN: begin
            if (scan_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (!p1_valid_ff && !p2_valid_ff) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         target_ff    <= '0;
         frac_ff      <= '0;
         p1_valid_ff  <= 1'b0;
         p2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         p1_valid_ff <= s0_valid;
         p2_valid_ff <= p1_valid_ff;
         // configuration writes
         if (csr_wr_en) begin
            unique case (csr_index)
               pfnm_pkg::CSR_TARGET_COLOR: target_ff <= csr_wdata;
               pfnm_pkg::CSR_FADE_FRAC:    frac_ff   <= csr_wdata;
               default: ;
            endcase
         end
         // result register
         if ((state_ff == S_DONE) && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      // query capture
      if (req_accept) begin
         idx_ff    <= req_data.entry_index;
         idx_ok_ff <= req_idx_ok;
         bestd_ff  <= '1;
         if (req_data.entry_index == '0) begin
            best_ff <= '0;
         end else begin
            best_ff <= target_ff;
         end
      end
      // original color and target range check
      if (state_ff == S_RD_TARG) begin
         orig_ff   <= idx_ok_ff ? rd_rgb : '0;
         tgt_ok_ff <= {1'b0, target_ff} < (IW + 1)'(PALETTE_ENTRIES);
      end
      // faded ideal color
      if (state_ff == S_FADE) begin
         ideal_ff.red   <= pfnm_pkg::fade_gun(orig_ff.red,   targ.red,   frac_ff[7:1]);
         ideal_ff.green <= pfnm_pkg::fade_gun(orig_ff.green, targ.green, frac_ff[7:1]);
         ideal_ff.blue  <= pfnm_pkg::fade_gun(orig_ff.blue,  targ.blue,  frac_ff[7:1]);
         cnt_ff         <= AW'(1);
      end
      // scan counter
      if ((state_ff == S_SCAN) && !scan_last) begin
         cnt_ff <= cnt_ff + AW'(1);
      end
      // candidate index pipeline
      cand1_ff <= cnt_ff;
      cand2_ff <= cand1_ff;
      // first strictly smaller distance wins
      if (p2_valid_ff && (cand_dist < bestd_ff)) begin
         bestd_ff <= cand_dist;
         best_ff  <= IW'(cand2_ff);
      end
      // result payload
      if ((state_ff == S_DONE) && rsp_free) begin
         rsp_ff.queried_index <= idx_ff;
         rsp_ff.match_color   <= best_ff;
      end
   end

endmodule

### dv/tb_palette_fade_nearest_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_palette_fade_nearest_match
// Self-checking bench for the palette fade nearest-match block. The palette is
// filled first. A short table of load and query items follows. After that come
// random phases at several target and fade settings. Each query result is
// checked against a pinned table value or a predictor with its own palette copy.
// ----------------------------------------------------------------------------
module tb_palette_fade_nearest_match;
   import pfnm_pkg::*;

   localparam int PHASES      = 9;
   localparam int PHASE_ITEMS = 107;
   localparam int SETTLE      = PALETTE_ENTRIES + 8;
   localparam int HOLD_CYCLES = 1200;

   typedef enum {STALL_NONE, STALL_RANDOM, STALL_PERIODIC, STALL_HEAVY} stall_pattern_type;

   typedef struct packed {
      req_type    item;
      logic       pinned;
      logic [7:0] pinned_match;
   } table_row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_type              req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_TARGET_COLOR;
   logic [CSR_W-1:0]     csr_wdata = '0;

   // predictor state: palette copy and register copies
   rgb_type    palette_copy [PALETTE_ENTRIES];
   logic [7:0] fade_target = '0;
   logic [7:0] fade_amount = '0;

   rsp_type    pending_matches [$];
   rsp_type    expected_rsp;
   rsp_type    seen_rsp;
   logic       pin_match = 1'b0;
   logic [7:0] pinned_value = '0;

   int mismatches     = 0;
   int loads_seen     = 0;
   int queries_seen   = 0;
   int zero_queries   = 0;
   int results_seen   = 0;
   int burst_left     = 0;
   bit gaps_on        = 1'b1;
   bit hold_request   = 1'b0;
   int hold_left      = 0;
   int stall_tick     = 0;
   stall_pattern_type stall_mode = STALL_NONE;

   // opening items: run at the reset settings, target 0 and no fade
   table_row_type opening_items [0:22] = '{
      '{'{MODE_LOAD,  8'd0,   8'h00, 8'h00, 8'h00}, 1'b0, 8'd0},
      '{'{MODE_LOAD,  8'd255, 8'hff, 8'hff, 8'hff}, 1'b0, 8'd0},
      '{'{MODE_LOAD,  8'd1,   8'hff, 8'hff, 8'hff}, 1'b0, 8'd0},
      '{'{MODE_QUERY, 8'd0,   8'h00, 8'h00, 8'h00}, 1'b1, 8'd0},
      '{'{MODE_QUERY, 8'd255, 8'h00, 8'h00, 8'h00}, 1'b0, 8'd0},
      '{'{MODE_QUERY, 8'd1,   8'h00, 8'h00, 8'h00}, 1'b0, 8'd0},
      '{'{MODE_LOAD,  8'd2,   8'h00, 8'h00, 8'h00}, 1'b0, 8'd0},
      '{'{MODE_QUERY, 8'd2,   8'h00, 8'h00, 8'h00}, 1'b0, 8'd0},
      '{'{MODE_LOAD,  8'd3,   8'hff, 8'h00, 8'h00}, 1'b0, 8'd0},
      '{'{MODE_LOAD,  8'd4,   8'h00, 8'hff, 8'h00}, 1'b0, 8'd0},
      '{'{MODE_LOAD,  8'd5,   8'h00, 8'h00, 8'hff}, 1'b0, 8'd0},
      '{'{MODE_QUERY, 8'd3,   8'h00, 8'h00, 8'h00}, 1'b0, 8'd0},
      '{'{MODE_QUERY, 8'd4,   8'h00, 8'h00, 8'h00}, 1'b0, 8'd0},
      '{'{MODE_QUERY, 8'd5,   8'h00, 8'h00, 8'h00}, 1'b0, 8'd0},
      '{'{MODE_LOAD,  8'd200, 8'h80, 8'h80, 8'h80}, 1'b0, 8'd0},
      '{'{MODE_LOAD,  8'd201, 8'h80, 8'h80, 8'h80}, 1'b0, 8'd0},
      '{'{MODE_QUERY, 8'd200, 8'hff, 8'hff, 8'hff}, 1'b0, 8'd0},
      '{'{MODE_QUERY, 8'd201, 8'hff, 8'hff, 8'hff}, 1'b0, 8'd0},
      '{'{MODE_LOAD,  8'd0,   8'h7f, 8'h7f, 8'h7f}, 1'b0, 8'd0},
      '{'{MODE_QUERY, 8'd0,   8'hff, 8'hff, 8'hff}, 1'b1, 8'd0},
      '{'{MODE_LOAD,  8'd254, 8'h01, 8'hfe, 8'h55}, 1'b0, 8'd0},
      '{'{MODE_QUERY, 8'd254, 8'h00, 8'h00, 8'h00}, 1'b0, 8'd0},
      '{'{MODE_QUERY, 8'd128, 8'h00, 8'h00, 8'h00}, 1'b0, 8'd0}
   };

   // phase settings, a negative entry means a random value
   int phase_target [PHASES] = '{0, 255, 255, -1, -1, 1, 128, -1, 0};
   int phase_frac   [PHASES] = '{255, 0, 255, -1, -1, 2, 1, -1, 128};

   palette_fade_nearest_match i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #1 clock = ~clock;

   // fade the remap entry toward the target and find the first nearest entry
   function automatic logic [7:0] nearest_faded_match(input logic [7:0] remap);
      rgb_type src;
      rgb_type tgt;
      rgb_type cand;
      int      half;
      int      orig [3];
      int      targ [3];
      int      ideal [3];
      int      gun_val [3];
      int      best;
      int      best_dist;
      int      cand_dist;
      if (remap == 8'd0) begin
         return 8'd0;
      end
      src  = palette_copy[remap];
      tgt  = palette_copy[fade_target];
      half = int'(fade_amount) >> 1;
      orig = '{int'(src.red), int'(src.green), int'(src.blue)};
      targ = '{int'(tgt.red), int'(tgt.green), int'(tgt.blue)};
      // floor shift of a signed product per gun, wrapped to 8 bits
      for (int g = 0; g < 3; g++) begin
         ideal[g] = (orig[g] - (((orig[g] - targ[g]) * half) >>> 7)) & 255;
      end
      best      = int'(fade_target);
      best_dist = 32'h7fff_ffff;
      for (int c = 1; c < PALETTE_ENTRIES; c++) begin
         if (c != int'(remap)) begin
            cand      = palette_copy[c];
            gun_val   = '{int'(cand.red), int'(cand.green), int'(cand.blue)};
            cand_dist = 0;
            for (int g = 0; g < 3; g++) begin
               cand_dist += (gun_val[g] - ideal[g]) * (gun_val[g] - ideal[g]);
            end
            if (cand_dist < best_dist) begin
               best_dist = cand_dist;
               best      = c;
            end
         end
      end
      return 8'(best);
   endfunction

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      mismatches++;
   endtask

   // track accepted items and check returned matches
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            seen_rsp = rsp_data;
            results_seen++;
            if (pending_matches.size() == 0) begin
               report_mismatch($sformatf("unexpected result index %0d match %0d",
                                         seen_rsp.queried_index, seen_rsp.match_color));
            end else begin
               expected_rsp = pending_matches.pop_front();
               if (seen_rsp.queried_index !== expected_rsp.queried_index)
                  report_mismatch($sformatf("queried_index got %0d want %0d",
                                            seen_rsp.queried_index,
                                            expected_rsp.queried_index));
               if (seen_rsp.match_color !== expected_rsp.match_color)
                  report_mismatch($sformatf("match_color for index %0d got %0d want %0d",
                                            expected_rsp.queried_index,
                                            seen_rsp.match_color,
                                            expected_rsp.match_color));
            end
         end
         if (req_valid && !req_stall) begin
            if (req_data.mode == MODE_LOAD) begin
               palette_copy[req_data.entry_index] = '{req_data.red_gun, req_data.green_gun,
                                                      req_data.blue_gun};
               loads_seen++;
            end else begin
               expected_rsp.queried_index = req_data.entry_index;
               expected_rsp.match_color   = pin_match ? pinned_value
                                            : nearest_faded_match(req_data.entry_index);
               pending_matches.push_back(expected_rsp);
               queries_seen++;
               if (req_data.entry_index == 8'd0)
                  zero_queries++;
            end
         end
      end
   end

   // result side stall pattern, with an occasional long hold-off
   always @(negedge clock) begin
      stall_tick++;
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (hold_request) begin
         hold_request = 1'b0;
         hold_left    = HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         case (stall_mode)
            STALL_NONE:     rsp_stall <= 1'b0;
            STALL_RANDOM:   rsp_stall <= ($urandom_range(0, 99) < 30);
            STALL_PERIODIC: rsp_stall <= ((stall_tick % 7) < 3);
            default:        rsp_stall <= ($urandom_range(0, 99) < 75);
         endcase
      end
   end

   // offer one item in bursts with random gaps; called and returns at a falling edge
   task automatic send_item(input req_type item, input logic pin, input logic [7:0] pinned);
      int gap;
      if (burst_left <= 0) begin
         gap        = gaps_on ? $urandom_range(1, 8) : 0;
         burst_left = $urandom_range(1, 24);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      pin_match    = pin;
      pinned_value = pinned;
      req_data  <= item;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      burst_left--;
   endtask

   // stop offering, wait for every pending match, then let the block settle
   task automatic drain_and_settle();
      req_valid <= 1'b0;
      burst_left = 0;
      while (pending_matches.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] which, input logic [7:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= which;
      csr_wdata <= value;
      if (which == CSR_TARGET_COLOR)
         fade_target = value;
      else
         fade_amount = value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   // random mix: queries, plain, corner and tie-making loads, load-then-query pairs
   task automatic send_random_items(input int count);
      req_type item;
      int      pick;
      for (int n = 0; n < count; n++) begin
         item.mode        = MODE_LOAD;
         item.entry_index = 8'($urandom);
         item.red_gun     = 8'($urandom);
         item.green_gun   = 8'($urandom);
         item.blue_gun    = 8'($urandom);
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            item.mode = MODE_QUERY;
         end else if (pick < 40) begin
            item.mode        = MODE_QUERY;
            item.entry_index = 8'd0;
         end else if (pick < 45) begin
            item.mode        = MODE_QUERY;
            item.entry_index = fade_target;
         end else if (pick < 60) begin
            item.mode = MODE_LOAD;
         end else if (pick < 70) begin
            // duplicate color so that the first-found rule decides
            {item.red_gun, item.green_gun, item.blue_gun} =
               palette_copy[$urandom_range(0, PALETTE_ENTRIES - 1)];
         end else if (pick < 78) begin
            item.red_gun   = $urandom_range(0, 1) ? 8'hff : 8'h00;
            item.green_gun = $urandom_range(0, 1) ? 8'hff : 8'h00;
            item.blue_gun  = $urandom_range(0, 1) ? 8'hff : 8'h00;
         end else begin
            send_item(item, 1'b0, 8'd0);
            item.mode = MODE_QUERY;
         end
         send_item(item, 1'b0, 8'd0);
      end
   endtask

   // main sequence
   initial begin
      req_type fill;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // every entry is loaded before the first query
      for (int i = 0; i < PALETTE_ENTRIES; i++) begin
         fill.mode        = MODE_LOAD;
         fill.entry_index = 8'(i);
         fill.red_gun     = 8'($urandom);
         fill.green_gun   = 8'($urandom);
         fill.blue_gun    = 8'($urandom);
         send_item(fill, 1'b0, 8'd0);
      end

      stall_mode = STALL_RANDOM;
      foreach (opening_items[r]) begin
         send_item(opening_items[r].item, opening_items[r].pinned,
                   opening_items[r].pinned_match);
      end
      drain_and_settle();

      for (int p = 0; p < PHASES; p++) begin
         write_csr(CSR_TARGET_COLOR, (phase_target[p] < 0) ? 8'($urandom)
                                                           : 8'(phase_target[p]));
         write_csr(CSR_FADE_FRAC, (phase_frac[p] < 0) ? 8'($urandom) : 8'(phase_frac[p]));
         stall_mode = stall_pattern_type'(p % 4);
         gaps_on    = (p % 3) != 1;
         if (p == 2 || p == 6)
            hold_request = 1'b1;
         send_random_items(PHASE_ITEMS);
         drain_and_settle();
      end

      $display("covered %0d loads and %0d queries (%0d at remap index zero) over %0d settings",
               loads_seen, queries_seen, zero_queries, PHASES + 1);
      $display("%0d results compared, %0d mismatches", results_seen, mismatches);
      if (mismatches == 0) begin
         $display("PASS palette_fade_nearest_match");
      end else begin
         $display("FAIL palette_fade_nearest_match");
      end
      $finish;
   end

   // run limit
   initial begin
      #6_000_000;
      $display("FAIL palette_fade_nearest_match");
      $finish;
   end

endmodule

### sim.f
hdl/pfnm_pkg.sv
hdl/pfnm_ram.sv
hdl/pfnm_dist.sv
hdl/palette_fade_nearest_match.sv
dv/tb_palette_fade_nearest_match.sv
